FILE: design/rmlu_pkg.sv
// ----------------------------------------------------------------------------
// rmlu_pkg
// shared types and codes of the recursive monitor lock unit
// ----------------------------------------------------------------------------
`default_nettype none

package rmlu_pkg;

    localparam int CMD_W   = 3;
    localparam int MON_W   = 6;
    localparam int THR_W   = 4;
    localparam int DEP_W   = 16;
    localparam int RES_W   = 4;
    localparam int STAMP_W = 16;

    // commands
    localparam logic [CMD_W-1:0] CMD_ENTER      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRY_ENTER  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NOTIFY     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NOTIFY_ALL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT    = 3'd6;
    localparam logic [CMD_W-1:0] CMD_FORGET     = 3'd7;

    // result codes
    localparam logic [RES_W-1:0] RES_OWNED       = 4'd0;
    localparam logic [RES_W-1:0] RES_QUEUED      = 4'd1;
    localparam logic [RES_W-1:0] RES_BUSY        = 4'd2;
    localparam logic [RES_W-1:0] RES_DONE        = 4'd3;
    localparam logic [RES_W-1:0] RES_NOT_OWNER   = 4'd4;
    localparam logic [RES_W-1:0] RES_OVERFLOW    = 4'd5;
    localparam logic [RES_W-1:0] RES_HANDOFF     = 4'd6;
    localparam logic [RES_W-1:0] RES_CANCELLED   = 4'd7;
    localparam logic [RES_W-1:0] RES_TIMED_OUT   = 4'd8;
    localparam logic [RES_W-1:0] RES_THREAD_BUSY = 4'd9;
    localparam logic [RES_W-1:0] RES_REQUEUED    = 4'd10;

    // thread status
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PAUSE = 2'd1;
    localparam logic [1:0] ST_LOCK  = 2'd2;
    localparam logic [1:0] ST_REACQ = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [MON_W-1:0] monitor_index;
        logic [THR_W-1:0] thread_id;
    } in_word_t;

    typedef struct packed {
        logic [RES_W-1:0] event_res;
        logic [THR_W-1:0] event_thread;
        logic [DEP_W-1:0] depth;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic             held;
        logic [THR_W-1:0] owner;
        logic [DEP_W-1:0] depth;
    } mon_rec_t;

    typedef struct packed {
        logic [MON_W-1:0]   target;
        logic [STAMP_W-1:0] stamp;
        logic [DEP_W-1:0]   saved;
    } thr_rec_t;

    typedef struct packed {
        logic emit;
        logic finish;
    } emit_ctl_t;

endpackage

`default_nettype wire

FILE: design/rmlu_out_stage.sv
// ----------------------------------------------------------------------------
// rmlu_out_stage
// one-deep look-behind plus output register; marks the final word of an item
// ----------------------------------------------------------------------------
`default_nettype none

module rmlu_out_stage
    import rmlu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire emit_ctl_t ctl,
    input  wire out_word_t res,
    input  wire logic      evt_stall,
    output logic           evt_valid,
    output out_word_t      evt_word,
    output logic           ready
);

    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      pend_valid_reg;
    out_word_t pend_word_reg;
    logic      out_free;

    assign out_free = !out_valid_reg || !evt_stall;
    assign ready    = !pend_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (ctl.finish && ready)
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
        else if (ctl.emit && ready)
        begin
            out_valid_reg  <= pend_valid_reg || (out_valid_reg && evt_stall);
            pend_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !evt_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish && ready && pend_valid_reg)
        begin
            out_word_reg <= '{event_res:    pend_word_reg.event_res,
                              event_thread: pend_word_reg.event_thread,
                              depth:        pend_word_reg.depth,
                              last:         1'b1};
        end
        else if (ctl.emit && ready)
        begin
            if (pend_valid_reg)
            begin
                out_word_reg <= '{event_res:    pend_word_reg.event_res,
                                  event_thread: pend_word_reg.event_thread,
                                  depth:        pend_word_reg.depth,
                                  last:         1'b0};
            end
            pend_word_reg <= res;
        end
    end

    assign evt_valid = out_valid_reg;
    assign evt_word  = out_word_reg;

endmodule

`default_nettype wire

FILE: design/recursive_monitor_lock_unit_top.sv
// ----------------------------------------------------------------------------
// recursive_monitor_lock_unit_top
// recursive monitor locks with wait / notify, fifo handoff by age stamps
// ----------------------------------------------------------------------------
// a plain command steps through the load, exec and fin states to its last word
// a grant search, notify or forget walks the thread table with a read and a
// check state per thread; notify_all repeats the walk per moved thread
// one command at a time; the thread table memory port sets the search time
// after reset a clearing pass zeroes the monitor table,
// cmd_stall stays high until it is done
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_monitor_lock_unit_top
    import rmlu_pkg::*;
#(
    parameter int MONITORS  = 64,
    parameter int THREADS   = 16,
    parameter int MAX_DEPTH = 65535
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire in_word_t  cmd_word,
    output logic           evt_valid,
    input  wire logic      evt_stall,
    output out_word_t      evt_word
);

    localparam int MIW = (MONITORS > 1) ? $clog2(MONITORS) : 1;
    localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_LOAD2 = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_SCK   = 4'd6;
    localparam logic [3:0] S_POST  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    // scan modes
    localparam logic [1:0] SM_ACQ    = 2'd0;
    localparam logic [1:0] SM_PAUSE  = 2'd1;
    localparam logic [1:0] SM_FORGET = 2'd2;

    function automatic out_word_t mk_word(input logic [RES_W-1:0] r,
                                          input logic [THR_W-1:0] th,
                                          input logic [DEP_W-1:0] d);
        out_word_t w;
        w.event_res    = r;
        w.event_thread = th;
        w.depth        = d;
        w.last         = 1'b0;
        return w;
    endfunction

    // sequencer and item registers
    logic [3:0]         state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [MON_W-1:0]   mon_reg, mon_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [MON_W-1:0]   cur_m_reg, cur_m_next;
    mon_rec_t           wrec_reg, wrec_next;
    logic               wb_reg, wb_next;
    logic [MIW-1:0]     clr_reg, clr_next;

    // scan of the thread table
    logic [TIW-1:0]     scan_reg, scan_next;
    logic [1:0]         mode_reg, mode_next;
    logic               best_valid_reg, best_valid_next;
    logic [TIW-1:0]     best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0] best_age_reg, best_age_next;
    logic [DEP_W-1:0]   best_saved_reg, best_saved_next;
    logic               any_reg, any_next;

    // thread status in flops, stamp counter
    logic [1:0]         status_reg [THREADS];
    logic [1:0]         status_next [THREADS];
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    // monitor table: held / owner / depth
    mon_rec_t           mon_mem [MONITORS];
    mon_rec_t           mon_rdata_reg;
    logic [MIW-1:0]     mr_addr;
    logic               mw_en;
    logic [MIW-1:0]     mw_addr;
    mon_rec_t           mw_data;

    // thread table: target / stamp / saved depth
    thr_rec_t           thr_mem [THREADS];
    thr_rec_t           thr_rdata_reg;
    logic [TIW-1:0]     tr_addr;
    logic               tw_en;
    logic [TIW-1:0]     tw_addr;
    thr_rec_t           tw_data;

    // result path
    emit_ctl_t          ectl;
    out_word_t          eres;
    logic               go;

    logic               t_bad;
    logic               m_bad;
    logic               tgt_bad;
    logic [1:0]         st_t;
    logic               owner;
    logic [1:0]         st_s;
    logic [STAMP_W-1:0] age;
    logic               hit;

    assign cmd_stall = (state_reg != S_IDLE);

    assign t_bad   = 32'(thr_reg) >= 32'(THREADS);
    assign m_bad   = 32'(mon_reg) >= 32'(MONITORS);
    assign tgt_bad = 32'(thr_rdata_reg.target) >= 32'(MONITORS);
    assign st_t    = t_bad ? ST_IDLE : status_reg[TIW'(thr_reg)];
    assign owner   = wrec_reg.held && (wrec_reg.owner == thr_reg);
    assign st_s    = status_reg[scan_reg];
    assign age     = stamp_reg - thr_rdata_reg.stamp;
    assign hit     = (mode_reg == SM_PAUSE) ? (st_s == ST_PAUSE)
                                            : (st_s == ST_LOCK || st_s == ST_REACQ);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        mon_next        = mon_reg;
        thr_next        = thr_reg;
        cur_m_next      = cur_m_reg;
        wrec_next       = wrec_reg;
        wb_next         = wb_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        mode_next       = mode_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_age_next   = best_age_reg;
        best_saved_next = best_saved_reg;
        any_next        = any_reg;
        status_next     = status_reg;
        stamp_next      = stamp_reg;
        mr_addr         = MIW'(mon_reg);
        mw_en           = 1'b0;
        mw_addr         = MIW'(cur_m_reg);
        mw_data         = wrec_reg;
        tr_addr         = TIW'(thr_reg);
        tw_en           = 1'b0;
        tw_addr         = TIW'(thr_reg);
        tw_data         = '{target: cur_m_reg, stamp: stamp_reg, saved: '0};
        ectl            = '0;
        eres            = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mw_en    = 1'b1;
                mw_addr  = clr_reg;
                mw_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MIW'(MONITORS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                mr_addr = MIW'(cmd_word.monitor_index);
                tr_addr = TIW'(cmd_word.thread_id);
                if (cmd_valid)
                begin
                    cmd_next   = cmd_word.command;
                    mon_next   = cmd_word.monitor_index;
                    thr_next   = cmd_word.thread_id;
                    wb_next    = 1'b0;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // a waiting thread's timeout goes to its own target monitor
                if (!t_bad && cmd_reg == CMD_TIMEOUT && st_t != ST_IDLE)
                begin
                    mr_addr = MIW'(thr_rdata_reg.target);
                end
                if (go)
                begin
                    if (t_bad)
                    begin
                        ectl.emit  = 1'b1;
                        eres       = mk_word(RES_THREAD_BUSY, thr_reg, '0);
                        state_next = S_FIN;
                    end
                    else if (cmd_reg == CMD_TIMEOUT)
                    begin
                        if (st_t != ST_IDLE)
                        begin
                            if (tgt_bad)
                            begin
                                status_next[TIW'(thr_reg)] = ST_IDLE;
                                ectl.emit  = 1'b1;
                                eres       = mk_word(RES_TIMED_OUT, thr_reg, '0);
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cur_m_next = thr_rdata_reg.target;
                                state_next = S_LOAD2;
                            end
                        end
                        else
                        begin
                            ectl.emit  = 1'b1;
                            eres       = mk_word(RES_DONE, thr_reg,
                                                 m_bad ? '0 : mon_rdata_reg.depth);
                            state_next = S_FIN;
                        end
                    end
                    else if (m_bad)
                    begin
                        ectl.emit  = 1'b1;
                        eres       = mk_word(RES_BUSY, thr_reg, '0);
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cur_m_next = mon_reg;
                        wrec_next  = mon_rdata_reg;
                        wb_next    = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_LOAD2:
            begin
                wrec_next  = mon_rdata_reg;
                wb_next    = 1'b1;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                if (go)
                begin
                    state_next = S_FIN;
                    if (cmd_reg == CMD_TIMEOUT)
                    begin
                        case (st_t)
                            ST_LOCK:
                            begin
                                status_next[TIW'(thr_reg)] = ST_IDLE;
                                ectl.emit = 1'b1;
                                eres      = mk_word(RES_TIMED_OUT, thr_reg, wrec_reg.depth);
                            end
                            ST_PAUSE:
                            begin
                                tw_en         = 1'b1;
                                tw_data.saved = thr_rdata_reg.saved;
                                status_next[TIW'(thr_reg)] = ST_REACQ;
                                stamp_next    = stamp_reg + 1'b1;
                                ectl.emit     = 1'b1;
                                eres          = mk_word(RES_REQUEUED, thr_reg, wrec_reg.depth);
                                if (!wrec_reg.held)
                                begin
                                    mode_next       = SM_ACQ;
                                    scan_next       = '0;
                                    best_valid_next = 1'b0;
                                    state_next      = S_SRD;
                                end
                            end
                            ST_REACQ:
                            begin
                                ectl.emit = 1'b1;
                                eres      = mk_word(RES_QUEUED, thr_reg, wrec_reg.depth);
                            end
                            default:
                            begin
                                state_next = S_FIN;
                            end
                        endcase
                    end
                    else if (cmd_reg == CMD_FORGET)
                    begin
                        mode_next  = SM_FORGET;
                        scan_next  = '0;
                        any_next   = 1'b0;
                        state_next = S_SRD;
                    end
                    else if (st_t != ST_IDLE)
                    begin
                        ectl.emit = 1'b1;
                        eres      = mk_word(RES_THREAD_BUSY, thr_reg, wrec_reg.depth);
                    end
                    else if (cmd_reg == CMD_ENTER || cmd_reg == CMD_TRY_ENTER)
                    begin
                        if (owner)
                        begin
                            ectl.emit = 1'b1;
                            if (wrec_reg.depth >= DEP_W'(MAX_DEPTH))
                            begin
                                eres = mk_word(RES_OVERFLOW, thr_reg, wrec_reg.depth);
                            end
                            else
                            begin
                                wrec_next.depth = wrec_reg.depth + 1'b1;
                                eres = mk_word(RES_OWNED, thr_reg, wrec_reg.depth + 1'b1);
                            end
                        end
                        else
                        begin
                            mode_next       = SM_ACQ;
                            scan_next       = '0;
                            best_valid_next = 1'b0;
                            state_next      = S_SRD;
                        end
                    end
                    else if (cmd_reg == CMD_EXIT || cmd_reg == CMD_WAIT)
                    begin
                        ectl.emit = 1'b1;
                        if (!owner)
                        begin
                            eres = mk_word(RES_NOT_OWNER, thr_reg, wrec_reg.depth);
                        end
                        else if (cmd_reg == CMD_EXIT && wrec_reg.depth > DEP_W'(1))
                        begin
                            wrec_next.depth = wrec_reg.depth - 1'b1;
                            eres = mk_word(RES_DONE, thr_reg, wrec_reg.depth - 1'b1);
                        end
                        else
                        begin
                            // release, park the caller on wait, then look for a taker
                            if (cmd_reg == CMD_WAIT)
                            begin
                                tw_en         = 1'b1;
                                tw_data.saved = wrec_reg.depth;
                                status_next[TIW'(thr_reg)] = ST_PAUSE;
                                stamp_next    = stamp_reg + 1'b1;
                            end
                            wrec_next       = '0;
                            eres            = mk_word((cmd_reg == CMD_EXIT) ? RES_DONE
                                                                            : RES_QUEUED,
                                                      thr_reg, '0);
                            mode_next       = SM_ACQ;
                            scan_next       = '0;
                            best_valid_next = 1'b0;
                            state_next      = S_SRD;
                        end
                    end
                    else
                    begin
                        if (!owner)
                        begin
                            ectl.emit = 1'b1;
                            eres      = mk_word(RES_NOT_OWNER, thr_reg, wrec_reg.depth);
                        end
                        else
                        begin
                            mode_next       = SM_PAUSE;
                            scan_next       = '0;
                            best_valid_next = 1'b0;
                            state_next      = S_SRD;
                        end
                    end
                end
            end

            S_SRD:
            begin
                tr_addr    = scan_reg;
                state_next = S_SCK;
            end

            S_SCK:
            begin
                tr_addr = scan_reg;
                if (go)
                begin
                    if (mode_reg == SM_FORGET)
                    begin
                        if (st_s != ST_IDLE && thr_rdata_reg.target == cur_m_reg)
                        begin
                            status_next[scan_reg] = ST_IDLE;
                            any_next  = 1'b1;
                            ectl.emit = 1'b1;
                            eres      = mk_word(RES_CANCELLED, THR_W'(scan_reg), '0);
                        end
                    end
                    else if (hit && thr_rdata_reg.target == cur_m_reg &&
                             (!best_valid_reg || age > best_age_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = scan_reg;
                        best_age_next   = age;
                        best_saved_next = thr_rdata_reg.saved;
                    end
                    if (scan_reg == TIW'(THREADS - 1))
                    begin
                        state_next = S_POST;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
            end

            S_POST:
            begin
                if (go)
                begin
                    state_next = S_FIN;
                    case (cmd_reg)
                        CMD_ENTER, CMD_TRY_ENTER:
                        begin
                            ectl.emit = 1'b1;
                            if (!wrec_reg.held && !best_valid_reg)
                            begin
                                wrec_next = '{held: 1'b1, owner: thr_reg, depth: DEP_W'(1)};
                                eres      = mk_word(RES_OWNED, thr_reg, DEP_W'(1));
                            end
                            else if (cmd_reg == CMD_ENTER)
                            begin
                                tw_en         = 1'b1;
                                tw_data.saved = DEP_W'(1);
                                status_next[TIW'(thr_reg)] = ST_LOCK;
                                stamp_next    = stamp_reg + 1'b1;
                                eres = mk_word(RES_QUEUED, thr_reg, wrec_reg.depth);
                            end
                            else
                            begin
                                eres = mk_word(RES_BUSY, thr_reg, wrec_reg.depth);
                            end
                        end
                        CMD_NOTIFY, CMD_NOTIFY_ALL:
                        begin
                            ectl.emit = 1'b1;
                            if (best_valid_reg)
                            begin
                                tw_en         = 1'b1;
                                tw_addr       = best_idx_reg;
                                tw_data.saved = best_saved_reg;
                                status_next[best_idx_reg] = ST_REACQ;
                                stamp_next    = stamp_reg + 1'b1;
                                eres = mk_word(RES_REQUEUED, THR_W'(best_idx_reg),
                                               wrec_reg.depth);
                                if (cmd_reg == CMD_NOTIFY)
                                begin
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    scan_next       = '0;
                                    best_valid_next = 1'b0;
                                    state_next      = S_SRD;
                                end
                            end
                            else
                            begin
                                eres = mk_word(RES_DONE, thr_reg, wrec_reg.depth);
                            end
                        end
                        CMD_FORGET:
                        begin
                            wrec_next = '0;
                            if (!any_reg)
                            begin
                                ectl.emit = 1'b1;
                                eres      = mk_word(RES_DONE, thr_reg, '0);
                            end
                        end
                        default:
                        begin
                            // exit, wait, timeout: hand the lock to the oldest taker
                            if (best_valid_reg)
                            begin
                                wrec_next = '{held: 1'b1, owner: THR_W'(best_idx_reg),
                                              depth: best_saved_reg};
                                status_next[best_idx_reg] = ST_IDLE;
                                ectl.emit = 1'b1;
                                eres = mk_word(RES_HANDOFF, THR_W'(best_idx_reg),
                                               best_saved_reg);
                            end
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (go)
                begin
                    ectl.emit  = 1'b1;
                    eres       = mk_word(RES_DONE, thr_reg, wrec_reg.depth);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (go)
                begin
                    ectl.finish = 1'b1;
                    mw_en       = wb_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            wb_reg         <= 1'b0;
            stamp_reg      <= '0;
            best_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            for (int i = 0; i < THREADS; i++)
            begin
                status_reg[i] <= ST_IDLE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            wb_reg         <= wb_next;
            stamp_reg      <= stamp_next;
            best_valid_reg <= best_valid_next;
            any_reg        <= any_next;
            status_reg     <= status_next;
        end
    end

    // item payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        mon_reg        <= mon_next;
        thr_reg        <= thr_next;
        cur_m_reg      <= cur_m_next;
        wrec_reg       <= wrec_next;
        scan_reg       <= scan_next;
        mode_reg       <= mode_next;
        best_idx_reg   <= best_idx_next;
        best_age_reg   <= best_age_next;
        best_saved_reg <= best_saved_next;
    end

    // monitor table memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            mon_mem[mw_addr] <= mw_data;
        end
        mon_rdata_reg <= mon_mem[mr_addr];
    end

    // thread table memory
    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            thr_mem[tw_addr] <= tw_data;
        end
        thr_rdata_reg <= thr_mem[tr_addr];
    end

    rmlu_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ectl),
        .res       (eres),
        .evt_stall (evt_stall),
        .evt_valid (evt_valid),
        .evt_word  (evt_word),
        .ready     (go)
    );

    // an accepted word always moves to the table read
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_LOAD))
        else $error("accepted word did not start a table read");

    // a released monitor is written back with zero depth
    a_free_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (mw_en && !mw_data.held) |-> (mw_data.depth == '0))
        else $error("free monitor written with nonzero depth");

    // the stamp counter moves only on an enqueue
    a_stamp_enq: assert property (@(posedge clk) disable iff (!rst_n)
        !tw_en |=> $stable(stamp_reg))
        else $error("stamp counter moved without an enqueue");

    // the thread scan never runs past the table
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRD || state_reg == S_SCK) |-> (32'(scan_reg) < 32'(THREADS)))
        else $error("thread scan out of range");

endmodule

`default_nettype wire
